// ----- sv/tff_pkg.sv -----
// Shared types, widths and constants for the triangle tangent frame block.
`timescale 1ns / 1ps

package tff_pkg;

   // Field widths
   localparam int COORD_WIDTH = 16;
   localparam int UV_W        = 16;
   localparam int NRM_W       = 16;
   localparam int TAN_W       = 16;
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;

   // Datapath widths
   localparam int DELTA_W = UV_W + 1;                 // uv delta
   localparam int EDGE_W  = COORD_WIDTH + 1;          // position edge
   localparam int DEN_W   = 2 * DELTA_W + 1;          // uv determinant
   localparam int NB_W    = DELTA_W + EDGE_W + 1;     // tangent / bitangent numerator
   localparam int AMAG_W  = NB_W - 1;                 // numerator magnitude
   localparam int A_W     = 30;                       // normalized magnitude
   localparam int CRS_W   = NRM_W + TAN_W + 1;        // cross product term
   localparam int X_W     = (NB_W > DEN_W + 1) ? NB_W : DEN_W + 1;
   localparam int Y_W     = CRS_W;
   localparam int P_W     = X_W + Y_W;
   localparam int ACC_W   = P_W + 2;
   localparam int THR_W   = CSR_W + DEN_W;
   localparam int SQ_W    = 2 * A_W + 4;
   localparam int ROOT_W  = A_W + 1;
   localparam int QUO_W   = 15;
   localparam int DIV_W   = A_W + QUO_W + 2;
   localparam int S_W     = $clog2(AMAG_W);
   localparam int TAN_SHIFT = 18;

   localparam logic signed [TAN_W-1:0] TAN_ONE = 16'sd16384;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DENOM_THR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH_THR = 2'd1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
      logic signed [UV_W-1:0]        tex_u;
      logic signed [UV_W-1:0]        tex_v;
      logic signed [NRM_W-1:0]       norm_x;
      logic signed [NRM_W-1:0]       norm_y;
      logic signed [NRM_W-1:0]       norm_z;
   } req_type;

   typedef struct packed {
      logic signed [TAN_W-1:0] tan_x;
      logic signed [TAN_W-1:0] tan_y;
      logic signed [TAN_W-1:0] tan_z;
      logic                    handed_negative;
   } rsp_type;

endpackage

// ----- sv/tff_mul.sv -----
// Shift-add signed multiplier shared by every product of the tangent frame.
`timescale 1ns / 1ps

module tff_mul
   import tff_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [X_W-1:0] x,
   input  logic signed [Y_W-1:0] y,
   output logic                  done,
   output logic signed [P_W:0]   prod
);

   logic           busy_ff, busy_in;
   logic [P_W-1:0] mx_ff, mp_ff;
   logic [Y_W-1:0] my_ff;
   logic           sgn_ff;
   logic [X_W-1:0] xmag;
   logic [Y_W-1:0] ymag;

   // Operand magnitudes
   assign xmag = x[X_W-1] ? X_W'(-x) : X_W'(x);
   assign ymag = y[Y_W-1] ? Y_W'(-y) : Y_W'(y);

   // Finished once the multiplier bits run out
   assign done    = busy_ff && (my_ff == '0);
   assign busy_in = start || (busy_ff && (my_ff != '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // One multiplier bit per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         mx_ff  <= P_W'(xmag);
         my_ff  <= ymag;
         mp_ff  <= '0;
         sgn_ff <= x[X_W-1] ^ y[Y_W-1];
      end else if (busy_ff && (my_ff != '0)) begin
         if (my_ff[0]) begin
            mp_ff <= mp_ff + mx_ff;
         end
         mx_ff <= mx_ff << 1;
         my_ff <= my_ff >> 1;
      end
   end

   assign prod = sgn_ff ? -$signed({1'b0, mp_ff}) : $signed({1'b0, mp_ff});

endmodule

// ----- sv/triangle_tangent_frame.sv -----
// Per-triangle unit tangent and handedness from a stream of vertex words.
//
// Usage: vertex words arrive on the req_ channel (valid/ready), three per
// triangle. The first two corners are stored as they arrive. The third
// starts the computation; one result word per triangle leaves on the rsp_
// channel (valid/ready). Thresholds are written through the csr_ channel,
// which is always ready; the user must write them only while the block is
// idle, as the block does not enforce it. The computation ends after the
// uv determinant when it is not above threshold. Else up to 27 products go
// one after the other through the shift-add multiplier (one multiplier bit
// per cycle), with a 32 step square root and three 15 step divisions after
// the length threshold product. req_ready is low for that whole time.
// A finished result sits in the output register; the block takes the next
// corners while the receiver stalls, and holds a later result until the
// register frees up.
// Reset (synchronous) clears the corner count, empties the output register
// and sets the thresholds to 17 and 1.
`timescale 1ns / 1ps

module triangle_tangent_frame
   import tff_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   // Sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MLOAD = 3'd1;
   localparam logic [2:0] ST_MWAIT = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_SQRT  = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_FIN   = 3'd7;

   localparam logic [1:0] CORNER_FIRST  = 2'd0;
   localparam logic [1:0] CORNER_SECOND = 2'd1;
   localparam logic [1:0] CORNER_THIRD  = 2'd2;
   localparam logic [1:0] COMP_LAST     = 2'd2;

   // Product steps
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_D0        = 5'd0;
   localparam logic [STEP_W-1:0] STEP_D1        = 5'd1;
   localparam logic [STEP_W-1:0] STEP_NB_FIRST  = 5'd2;
   localparam logic [STEP_W-1:0] STEP_NB_LAST   = 5'd13;
   localparam logic [STEP_W-1:0] STEP_SQ_FIRST  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_SQ_LAST   = 5'd16;
   localparam logic [STEP_W-1:0] STEP_THR       = 5'd17;
   localparam logic [STEP_W-1:0] STEP_C_FIRST   = 5'd18;
   localparam logic [STEP_W-1:0] STEP_C_LAST    = 5'd23;
   localparam logic [STEP_W-1:0] STEP_DOT_FIRST = 5'd24;
   localparam logic [STEP_W-1:0] STEP_DOT_LAST  = 5'd26;

   localparam logic [$clog2(QUO_W)-1:0] DIV_LAST = ($clog2(QUO_W))'(QUO_W - 1);

   // Control registers
   logic [2:0]        state_ff, state_in;
   logic [1:0]        corner_ff, corner_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CSR_W-1:0]  dth_ff, dth_in;
   logic [CSR_W-1:0]  lth_ff, lth_in;

   // Corner storage
   logic signed [COORD_WIDTH-1:0] p0_ff [3];
   logic signed [COORD_WIDTH-1:0] p1_ff [3];
   logic signed [COORD_WIDTH-1:0] p2_ff [3];
   logic signed [UV_W-1:0]        u0_ff [2];
   logic signed [UV_W-1:0]        u1_ff [2];
   logic signed [UV_W-1:0]        u2_ff [2];
   logic signed [NRM_W-1:0]       n0_ff [3];

   // Working registers
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [DEN_W-1:0]  d_ff;
   logic signed [NB_W-1:0]   n_ff [3];
   logic signed [NB_W-1:0]   b_ff [3];
   logic [AMAG_W-1:0]        a_ff [3];
   logic [S_W-1:0]           s_ff;
   logic [THR_W-1:0]         thr_ff;
   logic [SQ_W-1:0]          sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [1:0]               comp_ff;
   logic [DIV_W-1:0]         dv_rem_ff, dv_sh_ff;
   logic [QUO_W-1:0]         dv_q_ff;
   logic [$clog2(QUO_W)-1:0] dv_cnt_ff;
   logic signed [TAN_W-1:0]  t_ff [3];
   logic signed [CRS_W-1:0]  c_ff [3];
   logic                     hand_ff;
   rsp_type                  rsp_data_ff;

   // Combinational signals
   logic                    req_fire, rsp_load;
   logic signed [DELTA_W-1:0] d1u, d1v, d2u, d2v;
   logic signed [EDGE_W-1:0]  e1 [3];
   logic signed [EDGE_W-1:0]  e2 [3];
   logic [DEN_W-1:0]        aden;
   logic                    den_ok;
   logic [STEP_W-1:0]       k_nb, k_sq, k_c, k_d;
   logic [1:0]              ii_nb, c_ia, c_ib;
   logic signed [X_W-1:0]   mx;
   logic signed [Y_W-1:0]   my;
   logic                    mul_sub, mul_clr, mul_start, mul_done;
   logic signed [P_W:0]     mul_prod;
   logic signed [ACC_W-1:0] acc_base, acc_term, acc_in;
   logic [ACC_W-1:0]        acc_abs;
   logic                    acc_neg, acc_pos, a_big;
   logic [SQ_W-1:0]         sq_try;
   logic [ROOT_W-1:0]       len;
   logic [THR_W-1:0]        thr_sh;
   logic                    long_ok;
   logic [1:0]              comp_nx;
   logic [AMAG_W-1:0]       dv_a;
   logic [DIV_W-1:0]        init_rem, init_sh;
   logic                    dv_ge, dv_last;
   logic [QUO_W-1:0]        dv_q_next;
   logic signed [TAN_W-1:0] t_mag;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // Edges and uv deltas
   assign d1u = DELTA_W'(u1_ff[0]) - DELTA_W'(u0_ff[0]);
   assign d1v = DELTA_W'(u1_ff[1]) - DELTA_W'(u0_ff[1]);
   assign d2u = DELTA_W'(u2_ff[0]) - DELTA_W'(u0_ff[0]);
   assign d2v = DELTA_W'(u2_ff[1]) - DELTA_W'(u0_ff[1]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = EDGE_W'(p1_ff[i]) - EDGE_W'(p0_ff[i]);
         e2[i] = EDGE_W'(p2_ff[i]) - EDGE_W'(p0_ff[i]);
      end
   end

   assign aden   = d_ff[DEN_W-1] ? DEN_W'(-d_ff) : DEN_W'(d_ff);
   assign den_ok = aden > DEN_W'(dth_ff);

   // Step sub-indexes
   assign k_nb  = step_ff - STEP_NB_FIRST;
   assign k_sq  = step_ff - STEP_SQ_FIRST;
   assign k_c   = step_ff - STEP_C_FIRST;
   assign k_d   = step_ff - STEP_DOT_FIRST;
   assign ii_nb = k_nb[3:2];

   // Cross product pairing: c[i] = n[ia]*t[ib] - n[ib]*t[ia]
   always_comb begin
      case (k_c[2:1])
         2'd0:    begin c_ia = 2'd1; c_ib = 2'd2; end
         2'd1:    begin c_ia = 2'd2; c_ib = 2'd0; end
         default: begin c_ia = 2'd0; c_ib = 2'd1; end
      endcase
   end

   // Operand selection for the shared multiplier
   always_comb begin
      mx      = '0;
      my      = '0;
      mul_sub = 1'b0;
      mul_clr = 1'b0;
      unique case (step_ff) inside
         STEP_D0: begin
            mx = X_W'(d2v); my = Y_W'(d1u); mul_clr = 1'b1;
         end
         STEP_D1: begin
            mx = X_W'(d1v); my = Y_W'(d2u); mul_sub = 1'b1;
         end
         [STEP_NB_FIRST:STEP_NB_LAST]: begin
            case (k_nb[1:0])
               2'd0: begin mx = X_W'(e1[ii_nb]); my = Y_W'(d2v); mul_clr = 1'b1; end
               2'd1: begin mx = X_W'(e2[ii_nb]); my = Y_W'(d1v); mul_sub = 1'b1; end
               2'd2: begin mx = X_W'(e2[ii_nb]); my = Y_W'(d1u); mul_clr = 1'b1; end
               default: begin mx = X_W'(e1[ii_nb]); my = Y_W'(d2u); mul_sub = 1'b1; end
            endcase
         end
         [STEP_SQ_FIRST:STEP_SQ_LAST]: begin
            mx      = X_W'(a_ff[k_sq[1:0]][A_W-1:0]);
            my      = Y_W'(a_ff[k_sq[1:0]][A_W-1:0]);
            mul_clr = (step_ff == STEP_SQ_FIRST);
         end
         STEP_THR: begin
            mx = X_W'(aden); my = Y_W'(lth_ff); mul_clr = 1'b1;
         end
         [STEP_C_FIRST:STEP_C_LAST]: begin
            if (k_c[0]) begin
               mx = X_W'(t_ff[c_ia]); my = Y_W'(n0_ff[c_ib]); mul_sub = 1'b1;
            end else begin
               mx = X_W'(t_ff[c_ib]); my = Y_W'(n0_ff[c_ia]); mul_clr = 1'b1;
            end
         end
         [STEP_DOT_FIRST:STEP_DOT_LAST]: begin
            mx      = X_W'(b_ff[k_d[1:0]]);
            my      = Y_W'(c_ff[k_d[1:0]]);
            mul_clr = (step_ff == STEP_DOT_FIRST);
         end
         default: begin
            mx = '0;
         end
      endcase
   end

   assign mul_start = (state_ff == ST_MLOAD);

   tff_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mx),
      .y     (my),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // Accumulate the finished product
   assign acc_base = mul_clr ? '0 : acc_ff;
   assign acc_term = ACC_W'(mul_prod);
   assign acc_in   = mul_sub ? (acc_base - acc_term) : (acc_base + acc_term);
   assign acc_abs  = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);
   assign acc_neg  = acc_in[ACC_W-1];
   assign acc_pos  = !acc_in[ACC_W-1] && (acc_in != '0);

   // Normalizing shift: all magnitudes must fit A_W bits
   assign a_big = ((a_ff[0] >> A_W) != '0) || ((a_ff[1] >> A_W) != '0) ||
                  ((a_ff[2] >> A_W) != '0);

   // Square root step and length test
   assign sq_try  = sq_res_ff + sq_bit_ff;
   assign len     = sq_res_ff[ROOT_W-1:0];
   assign thr_sh  = thr_ff >> (s_ff + S_W'(TAN_SHIFT));
   assign long_ok = THR_W'(len) > thr_sh;

   // Divider setup and step
   assign comp_nx   = comp_ff + 2'd1;
   assign dv_a      = (state_ff == ST_SQRT) ? a_ff[0] : a_ff[comp_nx];
   assign init_rem  = DIV_W'({dv_a[A_W-1:0], {QUO_W{1'b0}}}) + DIV_W'(len);
   assign init_sh   = DIV_W'({len, 1'b0}) << (QUO_W - 1);
   assign dv_ge     = dv_rem_ff >= dv_sh_ff;
   assign dv_q_next = {dv_q_ff[QUO_W-2:0], dv_ge};
   assign dv_last   = (dv_cnt_ff == DIV_LAST);
   assign t_mag     = TAN_W'(dv_q_next);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      corner_in = corner_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (corner_ff == CORNER_THIRD) begin
                  corner_in = CORNER_FIRST;
                  step_in   = STEP_D0;
                  state_in  = ST_MLOAD;
               end else begin
                  corner_in = corner_ff + 2'd1;
               end
            end
         end
         ST_MLOAD: begin
            state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            if (mul_done) begin
               step_in  = step_ff + 1'b1;
               state_in = ST_MLOAD;
               if (step_ff == STEP_D1) begin
                  state_in = ST_CHECK;
               end else if (step_ff == STEP_NB_LAST) begin
                  state_in = ST_SHIFT;
               end else if (step_ff == STEP_THR) begin
                  state_in = ST_SQRT;
               end else if (step_ff == STEP_DOT_LAST) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_CHECK: begin
            state_in = den_ok ? ST_MLOAD : ST_FIN;
         end
         ST_SHIFT: begin
            if (!a_big) begin
               state_in = ST_MLOAD;
            end
         end
         ST_SQRT: begin
            if (sq_bit_ff == '0) begin
               state_in = long_ok ? ST_DIV : ST_MLOAD;
            end
         end
         ST_DIV: begin
            if (dv_last && (comp_ff == COMP_LAST)) begin
               state_in = ST_MLOAD;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register and thresholds
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign dth_in = (csr_valid && (csr_index == CSR_DENOM_THR))  ? csr_data : dth_ff;
   assign lth_in = (csr_valid && (csr_index == CSR_LENGTH_THR)) ? csr_data : lth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_D0;
         corner_ff    <= CORNER_FIRST;
         rsp_valid_ff <= 1'b0;
         dth_ff       <= 16'd17;
         lth_ff       <= 16'd1;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
         dth_ff       <= dth_in;
         lth_ff       <= lth_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      // corner capture
      if (req_fire) begin
         case (corner_ff)
            CORNER_FIRST: begin
               p0_ff[0] <= req_data.pos_x;
               p0_ff[1] <= req_data.pos_y;
               p0_ff[2] <= req_data.pos_z;
               u0_ff[0] <= req_data.tex_u;
               u0_ff[1] <= req_data.tex_v;
               n0_ff[0] <= req_data.norm_x;
               n0_ff[1] <= req_data.norm_y;
               n0_ff[2] <= req_data.norm_z;
            end
            CORNER_SECOND: begin
               p1_ff[0] <= req_data.pos_x;
               p1_ff[1] <= req_data.pos_y;
               p1_ff[2] <= req_data.pos_z;
               u1_ff[0] <= req_data.tex_u;
               u1_ff[1] <= req_data.tex_v;
            end
            default: begin
               p2_ff[0] <= req_data.pos_x;
               p2_ff[1] <= req_data.pos_y;
               p2_ff[2] <= req_data.pos_z;
               u2_ff[0] <= req_data.tex_u;
               u2_ff[1] <= req_data.tex_v;
               // default tangent until a normalized one replaces it
               t_ff[0]  <= TAN_ONE;
               t_ff[1]  <= '0;
               t_ff[2]  <= '0;
               hand_ff  <= 1'b0;
            end
         endcase
      end

      // product results
      if ((state_ff == ST_MWAIT) && mul_done) begin
         acc_ff <= acc_in;
         if (step_ff == STEP_D1) begin
            d_ff <= acc_in[DEN_W-1:0];
         end
         if ((step_ff >= STEP_NB_FIRST) && (step_ff <= STEP_NB_LAST)) begin
            if (k_nb[1:0] == 2'd1) begin
               n_ff[ii_nb] <= acc_in[NB_W-1:0];
               a_ff[ii_nb] <= acc_abs[AMAG_W-1:0];
            end else if (k_nb[1:0] == 2'd3) begin
               b_ff[ii_nb] <= acc_in[NB_W-1:0];
            end
         end
         if (step_ff == STEP_NB_LAST) begin
            s_ff <= '0;
         end
         if (step_ff == STEP_SQ_LAST) begin
            sq_rem_ff <= acc_in[SQ_W-1:0];
            sq_res_ff <= '0;
            sq_bit_ff <= SQ_W'(1) << (2 * A_W + 2);
         end
         if (step_ff == STEP_THR) begin
            thr_ff <= acc_in[THR_W-1:0];
         end
         if ((step_ff >= STEP_C_FIRST) && (step_ff <= STEP_C_LAST) && k_c[0]) begin
            c_ff[k_c[2:1]] <= acc_in[CRS_W-1:0];
         end
         if (step_ff == STEP_DOT_LAST) begin
            hand_ff <= (acc_neg && !d_ff[DEN_W-1]) || (acc_pos && d_ff[DEN_W-1]);
         end
      end

      // normalizing shift
      if ((state_ff == ST_SHIFT) && a_big) begin
         for (int i = 0; i < 3; i++) begin
            a_ff[i] <= a_ff[i] >> 1;
         end
         s_ff <= s_ff + 1'b1;
      end

      // square root, two result bits per step pair
      if (state_ff == ST_SQRT) begin
         if (sq_bit_ff != '0) begin
            if (sq_rem_ff >= sq_try) begin
               sq_rem_ff <= sq_rem_ff - sq_try;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end else if (long_ok) begin
            comp_ff   <= '0;
            dv_rem_ff <= init_rem;
            dv_sh_ff  <= init_sh;
            dv_q_ff   <= '0;
            dv_cnt_ff <= '0;
         end
      end

      // rounded division, one quotient bit per cycle
      if (state_ff == ST_DIV) begin
         if (dv_last) begin
            t_ff[comp_ff] <= (n_ff[comp_ff][NB_W-1] ^ d_ff[DEN_W-1]) ? -t_mag : t_mag;
            if (comp_ff != COMP_LAST) begin
               comp_ff   <= comp_nx;
               dv_rem_ff <= init_rem;
               dv_sh_ff  <= init_sh;
               dv_q_ff   <= '0;
               dv_cnt_ff <= '0;
            end
         end else begin
            if (dv_ge) begin
               dv_rem_ff <= dv_rem_ff - dv_sh_ff;
            end
            dv_sh_ff  <= dv_sh_ff >> 1;
            dv_q_ff   <= dv_q_next;
            dv_cnt_ff <= dv_cnt_ff + 1'b1;
         end
      end

      // result word
      if (rsp_load) begin
         rsp_data_ff.tan_x           <= t_ff[0];
         rsp_data_ff.tan_y           <= t_ff[1];
         rsp_data_ff.tan_z           <= t_ff[2];
         rsp_data_ff.handed_negative <= hand_ff;
      end
   end

   // Assertions
   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MWAIT))
      else $error("multiplier finished outside a product step");

   a_third_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (corner_ff == CORNER_THIRD)) |=>
      ((state_ff == ST_MLOAD) && (step_ff == STEP_D0) && (corner_ff == CORNER_FIRST)))
      else $error("third corner did not start the computation");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid && (state_ff == ST_IDLE)))
      else $error("result not presented after load");

   a_tan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.tan_x <= TAN_ONE) && (rsp_data.tan_x >= -TAN_ONE) &&
                     (rsp_data.tan_y <= TAN_ONE) && (rsp_data.tan_y >= -TAN_ONE) &&
                     (rsp_data.tan_z <= TAN_ONE) && (rsp_data.tan_z >= -TAN_ONE)))
      else $error("tangent component outside unit range");

endmodule
